/* sv/wpbt_pkg.sv */
// Shared types, register indexes and exp table builder for the W' balance tracker.
// No dependencies; used by w_prime_balance_tracker.
package wpbt_pkg;

   localparam int EXP_TABLE_DEPTH_DEF = 256;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WORK, ST_UDIV, ST_TDIV, ST_ADIV, ST_DECAY, ST_CLAMP,
      ST_FDIV, ST_EFF, ST_NMUL, ST_CDIV, ST_EXPLK, ST_EXPMUL, ST_HOLD
   } state_type;

   localparam logic [2:0] CSR_MODE    = 3'd0;
   localparam logic [2:0] CSR_WPRIME  = 3'd1;
   localparam logic [2:0] CSR_FTP     = 3'd2;
   localparam logic [2:0] CSR_TAU     = 3'd3;
   localparam logic [2:0] CSR_MAXEFF  = 3'd4;

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   // exp(-f), f and result in Q30, series summed through the 24th power of f
   function automatic logic [63:0] exp_frac_q30(input logic [63:0] f);
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] term;
      pos  = ONE_Q30;
      neg  = '0;
      term = ONE_Q30;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * f) >> 30) / 64'(k);
         if (k % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      return (neg > pos) ? 64'd0 : pos - neg;
   endfunction

   // table entry for argument x (Q30, below 16), result Q0.16 saturated
   function automatic logic [15:0] exp_entry(input logic [63:0] x);
      logic [63:0] e1;
      logic [63:0] n;
      logic [63:0] v;
      e1 = exp_frac_q30(ONE_Q30);
      n  = x >> 30;
      v  = exp_frac_q30(x & (ONE_Q30 - 64'd1));
      for (int q = 0; q < 16; q++) begin
         if (64'(q) < n) v = (v * e1 + (ONE_Q30 >> 1)) >> 30;
      end
      v = (v + 64'd8192) >> 14;
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

/* sv/w_prime_balance_tracker.sv */
// W' balance tracker top level: sequencer, bit-serial multiplier and divider.
// Depends on wpbt_pkg.
//
//  channel  ports        dir  payload
//  req      req_t*       in   power, step_time
//  rsp      rsp_t*       out  balance_joules, balance_fraction, effort_cap, expended_energy
//  csr      csr_*        in   register index, write data
//
// One transaction runs a sequence of bit-serial steps on a shift-add multiplier and a
// restoring divider, shared by all steps. The sequencer returns to idle after each
// transaction before it accepts the next. Reset is synchronous. A result waits in the
// output register while the next transaction is accepted; the last step holds until it
// is taken.
module w_prime_balance_tracker #(
   parameter int EXP_TABLE_DEPTH = wpbt_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [10:0] power, [26:11] step_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] balance_joules, [31:16] balance_fraction,
                                    // [47:32] effort_cap, [67:48] expended_energy
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

   logic [15:0] tab [EXP_TABLE_DEPTH];

   for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_tab
      localparam logic [63:0] XQ = ((64'(gi) * 64'd16) << 30) / 64'(EXP_TABLE_DEPTH);
      assign tab[gi] = wpbt_pkg::exp_entry(XQ);
   end

   wpbt_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic        run_ff, run_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [19:0] mc_ff, mc_in;
   logic [36:0] prod_ff, prod_in;
   logic [25:0] dv_ff, dv_in;
   logic [25:0] rem_ff, rem_in;
   logic [39:0] quo_ff, quo_in;
   logic [10:0] power_ff, power_in;
   logic [15:0] step_ff, step_in;
   logic [22:0] work_ff, work_in;
   logic [23:0] acc_ff, acc_in;
   logic [19:0] store_ff, store_in;
   logic [15:0] effort_ff, effort_in;
   logic [16:0] expu_ff, expu_in;
   logic [16:0] expres_ff, expres_in;
   logic [16:0] ea_ff, ea_in;
   logic [16:0] ediff_ff, ediff_in;
   logic [15:0] efr_ff, efr_in;
   logic [16:0] frac_ff, frac_in;
   logic        zneg_ff, zneg_in;
   logic [32:0] num_ff, num_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [71:0] rsp_tdata_ff, rsp_tdata_in;

   logic        mode_ff;
   logic [15:0] wp_ff;
   logic [10:0] ftp_ff;
   logic [11:0] tau_ff;
   logic [15:0] maxe_ff;

   // shared serial units
   logic [20:0] msum;
   logic [36:0] prod_step;
   logic [26:0] dt;
   logic        dge;
   logic [25:0] rem_step;
   logic [39:0] quo_step;
   logic        last;

   logic        above;
   logic [10:0] excess;
   logic [10:0] dpow;
   logic [19:0] cap16;
   logic [19:0] remj;
   logic        out_free;
   logic [16:0] quo_u;

   // exp lookup
   logic [31:0] pos;
   logic [IDX_W-1:0] idx;
   logic [IDX_W:0]   nxt;
   logic [16:0] ta, tb;

   // effort argument
   logic [21:0] t30;
   logic        zn;
   logic [21:0] zm;
   logic [17:0] zu;

   logic [25:0] tau_q;
   logic [17:0] cden;

   assign msum      = {1'b0, prod_ff[36:17]} + (prod_ff[0] ? {1'b0, mc_ff} : 21'd0);
   assign prod_step = {msum, prod_ff[16:1]};
   assign dt        = {rem_ff, quo_ff[39]};
   assign dge       = dt >= {1'b0, dv_ff};
   assign rem_step  = dge ? 26'(dt - {1'b0, dv_ff}) : dt[25:0];
   assign quo_step  = {quo_ff[38:0], dge};
   assign last      = run_ff && (cnt_ff == 6'd0);
   assign quo_u     = {|quo_step[39:16], quo_step[15:0]};

   assign above    = power_ff > ftp_ff;
   assign excess   = above ? power_ff - ftp_ff : 11'd0;
   assign dpow     = ftp_ff - power_ff;
   assign cap16    = {wp_ff, 4'b0000};
   assign remj     = cap16 - store_ff;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign pos = 32'(expu_ff[15:0]) * 32'(EXP_TABLE_DEPTH);
   assign idx = pos[16 +: IDX_W];
   assign nxt = {1'b0, idx} + {{IDX_W{1'b0}}, 1'b1};
   assign ta  = (idx == '0) ? 17'h10000 : {1'b0, tab[idx]};
   assign tb  = (nxt >= (IDX_W+1)'(EXP_TABLE_DEPTH)) ? 17'd0 : {1'b0, tab[nxt[IDX_W-1:0]]};

   assign t30 = 22'(frac_ff) * 22'd30;
   assign zn  = t30 < 22'd294912;
   assign zm  = zn ? 22'd294912 - t30 : t30 - 22'd294912;
   assign zu  = 18'((23'(zm) + 23'd8) >> 4);

   assign tau_q = 26'(26'(expres_ff) * 26'd546) + 26'(316 << 16);
   assign cden  = 18'h10000 + 18'(expres_ff);

   assign req_tready = state_ff == wpbt_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wpbt_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = wpbt_pkg::ST_WORK;
         end
         wpbt_pkg::ST_WORK: begin
            if (last) begin
               if (mode_ff) begin
                  state_in = (tau_ff == 12'd0) ? wpbt_pkg::ST_DECAY : wpbt_pkg::ST_ADIV;
               end else if (above) begin
                  state_in = wpbt_pkg::ST_CLAMP;
               end else begin
                  state_in = wpbt_pkg::ST_UDIV;
               end
            end
         end
         wpbt_pkg::ST_UDIV, wpbt_pkg::ST_TDIV, wpbt_pkg::ST_ADIV: begin
            if (last) state_in = wpbt_pkg::ST_EXPLK;
         end
         wpbt_pkg::ST_DECAY: begin
            if (last) state_in = wpbt_pkg::ST_CLAMP;
         end
         wpbt_pkg::ST_CLAMP: begin
            if (cap16 != 20'd0) state_in = wpbt_pkg::ST_FDIV;
            else state_in = mode_ff ? wpbt_pkg::ST_HOLD : wpbt_pkg::ST_EFF;
         end
         wpbt_pkg::ST_FDIV: begin
            if (last) state_in = mode_ff ? wpbt_pkg::ST_HOLD : wpbt_pkg::ST_EFF;
         end
         wpbt_pkg::ST_EFF: state_in = wpbt_pkg::ST_EXPLK;
         wpbt_pkg::ST_NMUL: begin
            if (!zneg_ff || last) state_in = wpbt_pkg::ST_CDIV;
         end
         wpbt_pkg::ST_CDIV: begin
            if (last) state_in = wpbt_pkg::ST_HOLD;
         end
         wpbt_pkg::ST_EXPLK: begin
            if (expu_ff == 17'd0 || expu_ff[16]) state_in = ret_ff;
            else state_in = wpbt_pkg::ST_EXPMUL;
         end
         wpbt_pkg::ST_EXPMUL: begin
            if (last) state_in = ret_ff;
         end
         wpbt_pkg::ST_HOLD: begin
            if (out_free) state_in = wpbt_pkg::ST_IDLE;
         end
         default: state_in = wpbt_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      ret_in        = ret_ff;
      run_in        = run_ff && !last;
      cnt_in        = run_ff ? cnt_ff - 6'd1 : cnt_ff;
      mc_in         = mc_ff;
      prod_in       = run_ff ? prod_step : prod_ff;
      dv_in         = dv_ff;
      rem_in        = run_ff ? rem_step : rem_ff;
      quo_in        = run_ff ? quo_step : quo_ff;
      power_in      = power_ff;
      step_in       = step_ff;
      work_in       = work_ff;
      acc_in        = acc_ff;
      store_in      = store_ff;
      effort_in     = effort_ff;
      expu_in       = expu_ff;
      expres_in     = expres_ff;
      ea_in         = ea_ff;
      ediff_in      = ediff_ff;
      efr_in        = efr_ff;
      frac_in       = frac_ff;
      zneg_in       = zneg_ff;
      num_in        = num_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      unique case (state_ff)
         wpbt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               power_in = req_tdata[10:0];
               step_in  = req_tdata[26:11];
            end
         end
         wpbt_pkg::ST_WORK: begin
            if (!run_ff) begin
               run_in  = 1'b1;
               cnt_in  = 6'd16;
               mc_in   = 20'(excess);
               prod_in = {20'd0, 1'b0, step_ff};
            end
            if (last) begin
               work_in = prod_step[26:4];
               acc_in  = 24'(store_ff) + 24'(prod_step[26:4]);
               if (mode_ff && tau_ff == 12'd0) expres_in = 17'd0;
            end
         end
         wpbt_pkg::ST_UDIV: begin
            if (!run_ff) begin
               run_in = 1'b1;
               cnt_in = 6'd39;
               dv_in  = 26'd100;
               rem_in = '0;
               quo_in = 40'({dpow, 12'd0}) + 40'd50;
            end
            if (last) begin
               expu_in = quo_u;
               ret_in  = wpbt_pkg::ST_TDIV;
            end
         end
         wpbt_pkg::ST_TDIV: begin
            if (!run_ff) begin
               run_in = 1'b1;
               cnt_in = 6'd39;
               dv_in  = tau_q;
               rem_in = '0;
               quo_in = 40'({step_ff, 20'd0}) + 40'(tau_q >> 1);
            end
            if (last) begin
               expu_in = quo_u;
               ret_in  = wpbt_pkg::ST_DECAY;
            end
         end
         wpbt_pkg::ST_ADIV: begin
            if (!run_ff) begin
               run_in = 1'b1;
               cnt_in = 6'd39;
               dv_in  = 26'(tau_ff);
               rem_in = '0;
               quo_in = 40'({step_ff, 4'd0}) + 40'(tau_ff >> 1);
            end
            if (last) begin
               expu_in = quo_u;
               ret_in  = wpbt_pkg::ST_DECAY;
            end
         end
         wpbt_pkg::ST_DECAY: begin
            if (!run_ff) begin
               run_in  = 1'b1;
               cnt_in  = 6'd16;
               mc_in   = store_ff;
               prod_in = {20'd0, expres_ff};
            end
            if (last) begin
               acc_in = 24'((38'(prod_step) + 38'd32768) >> 16)
                        + (mode_ff ? 24'(work_ff) : 24'd0);
            end
         end
         wpbt_pkg::ST_CLAMP: begin
            store_in = (acc_ff > 24'(cap16)) ? cap16 : acc_ff[19:0];
            if (cap16 == 20'd0) frac_in = 17'd0;
         end
         wpbt_pkg::ST_FDIV: begin
            if (!run_ff) begin
               run_in = 1'b1;
               cnt_in = 6'd39;
               dv_in  = 26'(cap16);
               rem_in = '0;
               quo_in = 40'({remj, 16'd0});
            end
            if (last) frac_in = quo_step[16:0];
         end
         wpbt_pkg::ST_EFF: begin
            zneg_in = zn;
            expu_in = {|zu[17:16], zu[15:0]};
            ret_in  = wpbt_pkg::ST_NMUL;
         end
         wpbt_pkg::ST_NMUL: begin
            if (!zneg_ff) begin
               num_in = 33'({maxe_ff, 16'd0});
            end else begin
               if (!run_ff) begin
                  run_in  = 1'b1;
                  cnt_in  = 6'd16;
                  mc_in   = 20'(maxe_ff);
                  prod_in = {20'd0, expres_ff};
               end
               if (last) num_in = prod_step[32:0];
            end
         end
         wpbt_pkg::ST_CDIV: begin
            if (!run_ff) begin
               run_in = 1'b1;
               cnt_in = 6'd39;
               dv_in  = 26'(cden);
               rem_in = '0;
               quo_in = 40'(num_ff) + 40'(cden >> 1);
            end
            if (last) effort_in = quo_step[15:0];
         end
         wpbt_pkg::ST_EXPLK: begin
            if (expu_ff == 17'd0) begin
               expres_in = 17'h10000;
            end else if (expu_ff[16]) begin
               expres_in = 17'd0;
            end else begin
               ea_in    = ta;
               ediff_in = (tb > ta) ? 17'd0 : ta - tb;
               efr_in   = pos[15:0];
            end
         end
         wpbt_pkg::ST_EXPMUL: begin
            if (!run_ff) begin
               run_in  = 1'b1;
               cnt_in  = 6'd16;
               mc_in   = 20'(ediff_ff);
               prod_in = {20'd0, 1'b0, efr_ff};
            end
            if (last) expres_in = ea_ff - prod_step[32:16];
         end
         wpbt_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'd0, store_ff, effort_ff,
                                (frac_ff[16] ? 16'hFFFF : frac_ff[15:0]), remj[19:4]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wpbt_pkg::ST_IDLE;
         ret_ff        <= wpbt_pkg::ST_IDLE;
         run_ff        <= 1'b0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         store_ff      <= '0;
         effort_ff     <= '0;
         mode_ff       <= 1'b0;
         wp_ff         <= 16'd20000;
         ftp_ff        <= 11'd250;
         tau_ff        <= 12'd400;
         maxe_ff       <= 16'd256;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         run_ff        <= run_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         store_ff      <= store_in;
         effort_ff     <= effort_in;
         if (csr_we) begin
            unique case (csr_addr)
               wpbt_pkg::CSR_MODE:   mode_ff <= csr_wdata[0];
               wpbt_pkg::CSR_WPRIME: wp_ff   <= csr_wdata;
               wpbt_pkg::CSR_FTP:    ftp_ff  <= csr_wdata[10:0];
               wpbt_pkg::CSR_TAU:    tau_ff  <= csr_wdata[11:0];
               wpbt_pkg::CSR_MAXEFF: maxe_ff <= csr_wdata;
               default: ;   // drop writes beyond the register list
            endcase
         end
      end
      mc_ff        <= mc_in;
      prod_ff      <= prod_in;
      dv_ff        <= dv_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      power_ff     <= power_in;
      step_ff      <= step_in;
      work_ff      <= work_in;
      acc_ff       <= acc_in;
      expu_ff      <= expu_in;
      expres_ff    <= expres_in;
      ea_ff        <= ea_in;
      ediff_ff     <= ediff_in;
      efr_ff       <= efr_in;
      frac_ff      <= frac_in;
      zneg_ff      <= zneg_in;
      num_ff       <= num_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

/* dv/wpbt_balance_monitor.sv */
// Monitor for the W' balance tracker: watches the req, rsp and csr channels, predicts each
// result with its own fixed-point model and compares it field by field. Depends on wpbt_pkg.
`timescale 1ns / 100ps
module wpbt_balance_monitor #(
   parameter int TABLE_DEPTH = wpbt_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [19:0] expended_energy;
      logic [15:0] effort_cap;
      logic [15:0] balance_fraction;
      logic [15:0] balance_joules;
   } balance_type;

   localparam logic [63:0] Q30 = 64'd1 << 30;

   logic [15:0] decay_rom [TABLE_DEPTH];
   logic [19:0] spent_q4;
   logic [15:0] effort_q8;
   logic        cfg_mode;
   logic [15:0] cfg_wprime;
   logic [10:0] cfg_ftp;
   logic [11:0] cfg_tau;
   logic [15:0] cfg_maxeff;
   balance_type balance_q[$];

   function automatic logic [63:0] series_exp_q30(input logic [63:0] f);
      logic [63:0] sum_pos;
      logic [63:0] sum_neg;
      logic [63:0] term;
      sum_pos = Q30;
      sum_neg = 0;
      term    = Q30;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * f) >> 30) / 64'(k);
         if (k % 2 == 1) sum_neg += term;
         else sum_pos += term;
      end
      return (sum_neg > sum_pos) ? 64'd0 : sum_pos - sum_neg;
   endfunction

   function automatic logic [63:0] rom_at(input logic [63:0] i);
      if (i == 0) return 64'd65536;
      if (i >= TABLE_DEPTH) return 64'd0;
      return 64'(decay_rom[i]);
   endfunction

   // exp(-u), u in Q4.12, result Q0.16 with 65536 as one
   function automatic logic [63:0] decay_q16(input logic [63:0] u);
      logic [63:0] p;
      logic [63:0] a;
      logic [63:0] b;
      if (u == 0) return 64'd65536;
      if (u >= 65536) return 64'd0;
      p = u * TABLE_DEPTH;
      a = rom_at(p >> 16);
      b = rom_at((p >> 16) + 1);
      if (b > a) b = a;
      return a - (((a - b) * (p & 64'hFFFF)) >> 16);
   endfunction

   function automatic logic [15:0] logistic_cap(input logic [63:0] spent, input logic [63:0] cap16);
      logic [63:0] x;
      logic [63:0] rem;
      logic [63:0] m;
      logic [63:0] e;
      logic [63:0] den;
      longint      z;
      x = 0;
      if (cap16 > 0) begin
         rem = (spent > cap16) ? 64'd0 : cap16 - spent;
         x = (rem * 65536) / cap16;
         if (x > 65536) x = 65536;
      end
      z = longint'(30 * x) - 294912;
      m = (z < 0) ? 64'(-z) : 64'(z);
      e = decay_q16((m + 8) >> 4);
      den = 65536 + e;
      if (z >= 0) return 16'((64'(cfg_maxeff) * 65536 + den / 2) / den);
      return 16'((64'(cfg_maxeff) * e + den / 2) / den);
   endfunction

   function automatic balance_type balance_step(input logic [10:0] power, input logic [15:0] step);
      balance_type r;
      logic [63:0] cap16;
      logic [63:0] acc;
      logic [63:0] excess;
      logic [63:0] tau_q16;
      logic [63:0] alpha;
      logic [63:0] rem;
      logic [63:0] frac;
      cap16  = 64'(cfg_wprime) * 16;
      acc    = 64'(spent_q4);
      excess = (power > cfg_ftp) ? 64'(power - cfg_ftp) : 64'd0;
      if (!cfg_mode) begin
         if (power > cfg_ftp) begin
            acc += (excess * step) >> 4;
         end else begin
            tau_q16 = 546 * decay_q16((64'(cfg_ftp - power) * 4096 + 50) / 100) + (64'd316 << 16);
            alpha = decay_q16(((64'(step) << 20) + tau_q16 / 2) / tau_q16);
            acc = (acc * alpha + 32768) >> 16;
         end
      end else begin
         alpha = (cfg_tau == 0) ? 64'd0 : decay_q16((64'(step) * 16 + cfg_tau / 2) / cfg_tau);
         acc = ((acc * alpha + 32768) >> 16) + ((excess * step) >> 4);
      end
      if (acc > cap16) acc = cap16;
      spent_q4 = acc[19:0];
      if (!cfg_mode) effort_q8 = logistic_cap(acc, cap16);
      rem = cap16 - acc;
      frac = (cap16 == 0) ? 64'd0 : (rem * 65536) / cap16;
      r.balance_joules   = rem[19:4];
      r.balance_fraction = (frac > 65535) ? 16'hFFFF : frac[15:0];
      r.effort_cap       = effort_q8;
      r.expended_energy  = acc[19:0];
      return r;
   endfunction

   initial begin
      logic [63:0] e1;
      logic [63:0] x;
      logic [63:0] v;
      e1 = series_exp_q30(Q30);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x = ((64'(i) * 16) << 30) / TABLE_DEPTH;
         v = series_exp_q30(x & (Q30 - 1));
         for (int q = 0; q < int'(x >> 30); q++) v = (v * e1 + (Q30 >> 1)) >> 30;
         v = (v + 8192) >> 14;
         decay_rom[i] = (v > 65535) ? 16'hFFFF : v[15:0];
      end
      fail_count = 0;
      checked    = 0;
   end

   assign pending = balance_q.size();

   always @(posedge clock) begin
      balance_type got;
      balance_type want;
      if (reset) begin
         effort_q8  = 0;
         spent_q4   = 0;
         cfg_mode   = 0;
         cfg_wprime = 20000;
         cfg_ftp    = 250;
         cfg_tau    = 400;
         cfg_maxeff = 256;
         balance_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               wpbt_pkg::CSR_MODE:   cfg_mode   = csr_wdata[0];
               wpbt_pkg::CSR_WPRIME: cfg_wprime = csr_wdata;
               wpbt_pkg::CSR_FTP:    cfg_ftp    = csr_wdata[10:0];
               wpbt_pkg::CSR_TAU:    cfg_tau    = csr_wdata[11:0];
               wpbt_pkg::CSR_MAXEFF: cfg_maxeff = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            balance_q.push_back(balance_step(req_tdata[10:0], req_tdata[26:11]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[67:0];
            checked++;
            if (balance_q.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing expected: %h", $time, got);
            end else begin
               want = balance_q.pop_front();
               if (got.balance_joules !== want.balance_joules) begin
                  fail_count++;
                  $display("%0t: balance_joules exp %0d got %0d", $time,
                           want.balance_joules, got.balance_joules);
               end
               if (got.balance_fraction !== want.balance_fraction) begin
                  fail_count++;
                  $display("%0t: balance_fraction exp %0d got %0d", $time,
                           want.balance_fraction, got.balance_fraction);
               end
               if (got.effort_cap !== want.effort_cap) begin
                  fail_count++;
                  $display("%0t: effort_cap exp %0d got %0d", $time,
                           want.effort_cap, got.effort_cap);
               end
               if (got.expended_energy !== want.expended_energy) begin
                  fail_count++;
                  $display("%0t: expended_energy exp %0d got %0d", $time,
                           want.expended_energy, got.expended_energy);
               end
            end
         end
      end
   end
endmodule

/* dv/testbench.sv */
// Testbench top for the W' balance tracker: clock, reset, stimulus and verdict.
// Depends on wpbt_pkg, w_prime_balance_tracker and wpbt_balance_monitor.
`timescale 1ns / 100ps
module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = 0;
   logic [15:0] csr_wdata = 0;
   int          fail_count;
   int          pending;
   int          checked;
   int          phases = 0;
   bit          calm = 0;

   always #10 clock = ~clock;

   w_prime_balance_tracker i_dut (.*);

   wpbt_balance_monitor i_monitor (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // sink stalls
   always @(negedge clock) begin
      int hold;
      if (reset) begin
         rsp_tready = 0;
      end else begin
         hold = gap_len();
         if (hold > 0) begin
            rsp_tready = 0;
            repeat (hold - 1) @(negedge clock);
         end else begin
            rsp_tready = 1;
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we    = 1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic send_sample(input logic [10:0] power, input logic [15:0] step);
      int hold;
      hold = gap_len();
      if (hold > 0) begin
         req_tvalid = 0;
         repeat (hold) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata  = {5'd0, step, power};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // drain, then let the block settle before touching registers
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (320) @(negedge clock);
   endtask

   task automatic configure(input logic m, input logic [15:0] wp, input logic [10:0] ftp,
                            input logic [11:0] tau, input logic [15:0] me);
      settle();
      write_reg(wpbt_pkg::CSR_MODE, 16'(m));
      write_reg(wpbt_pkg::CSR_WPRIME, wp);
      write_reg(wpbt_pkg::CSR_FTP, 16'(ftp));
      write_reg(wpbt_pkg::CSR_TAU, 16'(tau));
      write_reg(wpbt_pkg::CSR_MAXEFF, me);
      if ($urandom_range(0, 3) == 0) write_reg(3'd5 + 3'($urandom_range(0, 2)), 16'($urandom));
      phases++;
   endtask

   function automatic logic [15:0] pick16(input logic [15:0] a, input logic [15:0] b);
      case ($urandom_range(0, 4))
         0: return a;
         1: return b;
         2: return 16'($urandom_range(1, 300));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int          pw;
      logic [10:0] ftp;
      repeat (9) @(negedge clock);
      reset = 0;
      // directed: reset settings
      send_sample(11'd0, 16'd0);
      send_sample(11'd2047, 16'd65535);
      send_sample(11'd2047, 16'd65535);
      send_sample(11'd250, 16'd2560);
      send_sample(11'd0, 16'd65535);
      send_sample(11'd251, 16'd1);
      send_sample(11'd100, 16'd0);
      send_sample(11'd600, 16'd5000);
      // mode 1 with zero tau, then extreme tau
      configure(1, 16'd1000, 11'd0, 12'd0, 16'd65535);
      send_sample(11'd300, 16'd256);
      send_sample(11'd0, 16'd256);
      configure(1, 16'd65535, 11'd2047, 12'd4095, 16'd0);
      send_sample(11'd2047, 16'd65535);
      send_sample(11'd0, 16'd65535);
      configure(1, 16'd1000, 11'd100, 12'd1, 16'd256);
      send_sample(11'd2047, 16'd65535);
      send_sample(11'd50, 16'd1);
      // capacity lowered under a full store, then zero capacity in mode 0
      configure(0, 16'd5, 11'd0, 12'd400, 16'd65535);
      send_sample(11'd0, 16'd0);
      send_sample(11'd2047, 16'd4000);
      configure(0, 16'd0, 11'd2047, 12'd400, 16'd65535);
      send_sample(11'd2047, 16'd100);
      send_sample(11'd1000, 16'd100);
      configure(0, 16'd65535, 11'd2047, 12'd400, 16'd256);
      send_sample(11'd0, 16'd65535);
      // random phases
      for (int ph = 0; ph < 10; ph++) begin
         ftp = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(100, 400));
         configure(1'($urandom), pick16(16'd0, 16'd65535), ftp,
                   12'(pick16(16'd1, 16'd4095)), pick16(16'd0, 16'd65535));
         calm = (ph % 3 == 2);
         for (int n = 0; n < 133; n++) begin
            if ($urandom_range(0, 4) == 0) pw = $urandom_range(0, 2047);
            else pw = int'(ftp) + $urandom_range(0, 500) - 300;
            if (pw < 0) pw = 0;
            if (pw > 2047) pw = 2047;
            send_sample(11'(pw), ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 2047)));
         end
      end
      calm = 0;
      while (pending != 0) @(negedge clock);
      repeat (320) @(negedge clock);
      $display("Ran %0d configuration phases, %0d results compared.", phases, checked);
      $display("Covered both modes, zero/full capacity, zero tau and extreme power and step.");
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Timeout with %0d results outstanding.", pending);
      $display("*** FAILED ***");
      $finish;
   end
endmodule
